// File: design/iepm_pkg.sv
// Package for the I2C EEPROM paged master: phase and stage codes, field widths.
// No dependencies.
`default_nettype none
package iepm_pkg;
    localparam int BufDepth = 256;
    localparam int BufAw    = $clog2(BufDepth);

    typedef enum logic [18:0] {
        P_IDLE  = 19'd1 << 0,  P_ST0   = 19'd1 << 1,  P_ST1   = 19'd1 << 2,
        P_ST2   = 19'd1 << 3,  P_ST3   = 19'd1 << 4,  P_TXLO  = 19'd1 << 5,
        P_TXHI  = 19'd1 << 6,  P_TXEND = 19'd1 << 7,  P_ACKHI = 19'd1 << 8,
        P_ACKEND= 19'd1 << 9,  P_RXLO  = 19'd1 << 10, P_RXHI  = 19'd1 << 11,
        P_MALO  = 19'd1 << 12, P_MAHI  = 19'd1 << 13, P_MAEND = 19'd1 << 14,
        P_SP0   = 19'd1 << 15, P_SP1   = 19'd1 << 16, P_SP2   = 19'd1 << 17,
        P_WAIT  = 19'd1 << 18
    } t_phase;

    typedef enum logic [2:0] {
        STG_DEVW = 3'd0, STG_WORD = 3'd1, STG_DATA = 3'd2,
        STG_DEVR = 3'd3, STG_READ = 3'd4, STG_FAIL = 3'd5
    } t_stage;

    localparam logic [1:0] F_TICK = 2'd0;
    localparam logic [1:0] F_LOAD = 2'd1;
    localparam logic [1:0] F_WR   = 2'd2;
    localparam logic [1:0] F_RD   = 2'd3;

    localparam logic [2:0] R_DEV  = 3'd0;
    localparam logic [2:0] R_PAGE = 3'd1;
    localparam logic [2:0] R_TMO  = 3'd2;
    localparam logic [2:0] R_WCYC = 3'd3;
    localparam logic [2:0] R_RTRY = 3'd4;

    typedef struct packed {
        logic [1:0] func;
        logic [7:0] byte_value;
        logic [7:0] mem_addr;
        logic [7:0] length;
        logic       sda_in;
    } t_item;

    typedef struct packed {
        logic       scl;
        logic       sda_out;
        logic       sda_enable;
        logic [7:0] read_byte;
        logic       read_valid;
        logic       busy_res;
        logic       done_res;
        logic       status;
    } t_res;

    typedef struct packed {
        logic [6:0]  dev;
        logic [2:0]  page;
        logic [7:0]  tmo;
        logic [15:0] wcyc;
        logic [3:0]  rtry;
    } t_cfg;

    // buffer access between sequencer and buffer
    typedef struct packed {
        logic             we;
        logic [BufAw-1:0] waddr;
        logic [7:0]       wdata;
        logic [BufAw-1:0] raddr;
    } t_buf_req;
endpackage
`default_nettype wire

// File: design/i2c_eeprom_paged_master.sv
// Top level of the I2C EEPROM paged master: stream ports, config, buffer, sequencer.
// Depends on iepm_pkg, iepm_cfg, iepm_buf, iepm_seq.
//
// channel   dir  payload
// s_axis    in   item: func, byte_value, mem_addr, length, sda_in (one bus phase)
// m_axis    out  result: scl, sda_out, sda_enable, read_byte, read_valid, busy, done, status
// cfg       in   write enable, register index, 16-bit data
//
// One item per cycle while the output is not stalled; its result appears in the output register the next cycle.
// Rate is set by the single-phase sequencer step; the output register holds one result.
// Reset is synchronous and active low; buffer contents are not cleared.
// An item is taken whenever the output register is empty or being emptied.
`default_nettype none
module i2c_eeprom_paged_master (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // [1:0] func, [9:2] byte_value, [17:10] mem_addr, [25:18] length, [26] sda_in
    input  wire logic [31:0] s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [0] scl, [1] sda_out, [2] sda_enable, [10:3] read_byte, [11] read_valid,
    // [12] busy_res, [13] done_res, [14] status
    output logic [15:0]      m_axis_tdata,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data
);
    iepm_pkg::t_cfg     cfg;
    iepm_pkg::t_item    item;
    iepm_pkg::t_res     res;
    iepm_pkg::t_buf_req breq;
    logic [7:0]         brd;
    logic               go;
    logic               r_vld;

    assign item.func       = s_axis_tdata[1:0];
    assign item.byte_value = s_axis_tdata[9:2];
    assign item.mem_addr   = s_axis_tdata[17:10];
    assign item.length     = s_axis_tdata[25:18];
    assign item.sda_in     = s_axis_tdata[26];

    assign s_axis_tready = !r_vld || m_axis_tready;
    assign go = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vld <= 1'b0;
        else if (s_axis_tready) r_vld <= s_axis_tvalid;
    end

    iepm_cfg u_cfg (.i_clk, .i_rst_n, .i_cfg_we, .i_cfg_index, .i_cfg_data, .o_cfg(cfg));
    iepm_buf u_buf (.i_clk, .i_req(breq), .o_rdata(brd));
    iepm_seq u_seq (.i_clk, .i_rst_n, .i_cfg(cfg), .i_go(go), .i_item(item),
                    .i_buf_rdata(brd), .o_buf_req(breq), .o_res(res));

    assign m_axis_tvalid = r_vld;
    assign m_axis_tdata  = {1'b0, res.status, res.done_res, res.busy_res, res.read_valid,
                            res.read_byte, res.sda_enable, res.sda_out, res.scl};
endmodule
`default_nettype wire

// File: design/iepm_cfg.sv
// Configuration register file for the I2C EEPROM master.
// Depends on iepm_pkg.
`default_nettype none
module iepm_cfg (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_cfg_we,
    input  wire logic [2:0]     i_cfg_index,
    input  wire logic [15:0]    i_cfg_data,
    output iepm_pkg::t_cfg      o_cfg
);
    iepm_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.dev  <= 7'd80;
            r_cfg.page <= 3'd3;
            r_cfg.tmo  <= 8'd255;
            r_cfg.wcyc <= 16'd2000;
            r_cfg.rtry <= 4'd5;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                iepm_pkg::R_DEV:  r_cfg.dev  <= i_cfg_data[6:0];
                iepm_pkg::R_PAGE: r_cfg.page <= i_cfg_data[2:0];
                iepm_pkg::R_TMO:  r_cfg.tmo  <= i_cfg_data[7:0];
                iepm_pkg::R_WCYC: r_cfg.wcyc <= i_cfg_data;
                iepm_pkg::R_RTRY: r_cfg.rtry <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;
endmodule
`default_nettype wire

// File: design/iepm_buf.sv
// Write byte buffer: one write port, one asynchronous-free read port.
// Read data is registered; the address is presented in the cycle before the data. Depends on iepm_pkg.
`default_nettype none
module iepm_buf (
    input  wire logic               i_clk,
    input  iepm_pkg::t_buf_req      i_req,
    output logic [7:0]              o_rdata
);
    logic [7:0] r_mem [iepm_pkg::BufDepth];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) r_mem[i_req.waddr] <= i_req.wdata;
        r_rdata <= r_mem[i_req.raddr];
    end

    assign o_rdata = r_rdata;
endmodule
`default_nettype wire

// File: design/iepm_seq.sv
// Bus phase sequencer: one item per cycle while i_go is high, state update and registered result.
// Depends on iepm_pkg; buffer data arrives registered from iepm_buf.
`default_nettype none
module iepm_seq (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  iepm_pkg::t_cfg          i_cfg,
    input  wire logic               i_go,
    input  iepm_pkg::t_item         i_item,
    input  wire logic [7:0]         i_buf_rdata,
    output iepm_pkg::t_buf_req      o_buf_req,
    output iepm_pkg::t_res          o_res
);
    iepm_pkg::t_phase r_ph, n_ph;
    iepm_pkg::t_stage r_stg, n_stg;
    logic [3:0]  r_bc, n_bc;
    logic [7:0]  r_sh, n_sh;
    logic [7:0]  r_aw, n_aw;
    logic [7:0]  r_ca, n_ca;
    logic [7:0]  r_bl, n_bl;
    logic [7:0]  r_cl, n_cl;
    logic [7:0]  r_sa, n_sa;
    logic [7:0]  r_sl, n_sl;
    logic [7:0]  r_ri, n_ri;
    logic [7:0]  r_li, n_li;
    logic [3:0]  r_at, n_at;
    logic [15:0] r_dc, n_dc;
    logic        r_rd, n_rd;
    iepm_pkg::t_res n_res;

    logic        nack, begin_tx, restart, load, txbit;
    logic [7:0]  load_val, bt_ca, bt_bl, rd_addr;
    logic [8:0]  page, remain;
    logic [7:0]  tmo_eff;
    logic [3:0]  rtry_eff;

    always_comb begin
        n_ph = r_ph; n_stg = r_stg; n_bc = r_bc; n_sh = r_sh; n_aw = r_aw;
        n_ca = r_ca; n_bl = r_bl; n_cl = r_cl; n_sa = r_sa; n_sl = r_sl;
        n_ri = r_ri; n_li = r_li; n_at = r_at; n_dc = r_dc; n_rd = r_rd;
        n_res = '0;
        n_res.scl = 1'b1; n_res.sda_out = 1'b1; n_res.sda_enable = 1'b1;
        nack = (r_bl == 8'd0);
        begin_tx = 1'b0; restart = 1'b0; load = 1'b0; load_val = 8'd0;
        tmo_eff  = (i_cfg.tmo == 8'd0) ? 8'd1 : i_cfg.tmo;
        rtry_eff = (i_cfg.rtry == 4'd0) ? 4'd1 : i_cfg.rtry;
        txbit = r_sh[3'd7 - r_bc[2:0]];
        o_buf_req = '0;
        o_buf_req.waddr = r_li[iepm_pkg::BufAw-1:0];
        o_buf_req.wdata = i_item.byte_value;

        case (r_ph)
            iepm_pkg::P_IDLE: begin
                if (i_item.func == iepm_pkg::F_LOAD) begin
                    o_buf_req.we = i_go;
                    n_li = r_li + 8'd1;
                end else if (i_item.func == iepm_pkg::F_WR ||
                             i_item.func == iepm_pkg::F_RD) begin
                    n_sa = i_item.mem_addr;
                    n_sl = i_item.length;
                    n_rd = (i_item.func == iepm_pkg::F_RD);
                    n_at = 4'd0;
                    if (i_item.func == iepm_pkg::F_WR) n_li = 8'd0;
                    restart = 1'b1;
                end
            end
            iepm_pkg::P_ST0: begin n_res.scl = 1'b0; n_ph = iepm_pkg::P_ST1; end
            iepm_pkg::P_ST1: n_ph = iepm_pkg::P_ST2;
            iepm_pkg::P_ST2: begin n_res.sda_out = 1'b0; n_ph = iepm_pkg::P_ST3; end
            iepm_pkg::P_ST3: begin
                n_res.scl = 1'b0; n_res.sda_out = 1'b0;
                load = 1'b1;
                load_val = {i_cfg.dev, r_stg == iepm_pkg::STG_DEVR};
            end
            iepm_pkg::P_TXLO: begin
                n_res.scl = 1'b0; n_res.sda_out = txbit; n_ph = iepm_pkg::P_TXHI;
            end
            iepm_pkg::P_TXHI: begin
                n_res.sda_out = txbit;
                n_bc = r_bc + 4'd1;
                n_ph = (n_bc >= 4'd8) ? iepm_pkg::P_TXEND : iepm_pkg::P_TXLO;
            end
            iepm_pkg::P_TXEND: begin
                n_res.scl = 1'b0; n_res.sda_out = r_sh[0];
                n_aw = 8'd0; n_ph = iepm_pkg::P_ACKHI;
            end
            iepm_pkg::P_ACKHI: begin
                n_res.sda_out = 1'b0; n_res.sda_enable = 1'b0;
                if (!i_item.sda_in) n_ph = iepm_pkg::P_ACKEND;
                else begin
                    if (r_aw != 8'd255) n_aw = r_aw + 8'd1;
                    if (n_aw >= tmo_eff) begin
                        n_stg = iepm_pkg::STG_FAIL; n_ph = iepm_pkg::P_SP0;
                    end
                end
            end
            iepm_pkg::P_ACKEND: begin
                n_res.scl = 1'b0; n_res.sda_out = 1'b0; n_res.sda_enable = 1'b0;
                case (r_stg)
                    iepm_pkg::STG_DEVW: begin
                        n_stg = iepm_pkg::STG_WORD; load = 1'b1; load_val = r_ca;
                    end
                    iepm_pkg::STG_WORD: begin
                        if (r_rd) begin
                            n_stg = iepm_pkg::STG_DEVR; n_ph = iepm_pkg::P_ST0;
                        end else if (r_cl != 8'd0) begin
                            n_stg = iepm_pkg::STG_DATA; load = 1'b1;
                            load_val = i_buf_rdata;
                        end else n_ph = iepm_pkg::P_SP0;
                    end
                    iepm_pkg::STG_DATA: begin
                        n_ri = r_ri + 8'd1; n_ca = r_ca + 8'd1;
                        n_bl = r_bl - 8'd1; n_cl = r_cl - 8'd1;
                        // next entry was fetched ahead during the ACK phase
                        if (n_cl != 8'd0) begin
                            n_stg = iepm_pkg::STG_DATA; load = 1'b1;
                            load_val = i_buf_rdata;
                        end else n_ph = iepm_pkg::P_SP0;
                    end
                    default: begin
                        n_stg = iepm_pkg::STG_READ; n_bc = 4'd0; n_sh = 8'd0;
                        n_ph = nack ? iepm_pkg::P_MALO : iepm_pkg::P_RXLO;
                    end
                endcase
            end
            iepm_pkg::P_RXLO: begin
                n_res.scl = 1'b0; n_res.sda_out = 1'b0; n_res.sda_enable = 1'b0;
                n_ph = iepm_pkg::P_RXHI;
            end
            iepm_pkg::P_RXHI: begin
                n_res.sda_out = 1'b0; n_res.sda_enable = 1'b0;
                n_sh = {r_sh[6:0], i_item.sda_in};
                n_bc = r_bc + 4'd1;
                if (n_bc >= 4'd8) begin
                    n_res.read_valid = 1'b1; n_res.read_byte = n_sh;
                    n_bl = r_bl - 8'd1; n_ph = iepm_pkg::P_MALO;
                end else n_ph = iepm_pkg::P_RXLO;
            end
            iepm_pkg::P_MALO: begin
                n_res.scl = 1'b0; n_res.sda_out = nack; n_ph = iepm_pkg::P_MAHI;
            end
            iepm_pkg::P_MAHI: begin n_res.sda_out = nack; n_ph = iepm_pkg::P_MAEND; end
            iepm_pkg::P_MAEND: begin
                n_res.scl = 1'b0; n_res.sda_out = nack;
                if (nack) n_ph = iepm_pkg::P_SP0;
                else begin n_bc = 4'd0; n_sh = 8'd0; n_ph = iepm_pkg::P_RXLO; end
            end
            iepm_pkg::P_SP0: begin
                n_res.scl = 1'b0; n_res.sda_out = 1'b0; n_ph = iepm_pkg::P_SP1;
            end
            iepm_pkg::P_SP1: begin n_res.sda_out = 1'b0; n_ph = iepm_pkg::P_SP2; end
            iepm_pkg::P_SP2: begin
                if (r_stg == iepm_pkg::STG_FAIL) begin
                    n_at = r_at + 4'd1;
                    if (n_at >= rtry_eff) begin
                        n_res.done_res = 1'b1; n_res.status = 1'b1;
                        n_ph = iepm_pkg::P_IDLE;
                    end else restart = 1'b1;
                end else if (r_rd) begin
                    n_res.done_res = 1'b1; n_ph = iepm_pkg::P_IDLE;
                end else if (i_cfg.wcyc != 16'd0) begin
                    n_dc = i_cfg.wcyc; n_ph = iepm_pkg::P_WAIT;
                end else if (r_bl != 8'd0) begin_tx = 1'b1;
                else begin n_res.done_res = 1'b1; n_ph = iepm_pkg::P_IDLE; end
            end
            iepm_pkg::P_WAIT: begin
                n_dc = r_dc - 16'd1;
                if (n_dc == 16'd0) begin
                    if (r_bl != 8'd0) begin_tx = 1'b1;
                    else begin n_res.done_res = 1'b1; n_ph = iepm_pkg::P_IDLE; end
                end
            end
            default: n_ph = iepm_pkg::P_IDLE;
        endcase

        if (restart) begin
            n_ca = n_sa; n_bl = n_sl; n_ri = 8'd0; begin_tx = 1'b1;
        end
        bt_ca = n_ca; bt_bl = n_bl;
        page   = 9'd1 << i_cfg.page;
        remain = page - ({1'b0, bt_ca} & (page - 9'd1));
        if (begin_tx) begin
            n_stg = iepm_pkg::STG_DEVW;
            if (!n_rd) n_cl = ({1'b0, bt_bl} < remain) ? bt_bl : remain[7:0];
            n_ph = iepm_pkg::P_ST0;
        end
        if (load) begin
            n_sh = load_val; n_bc = 4'd0; n_ph = iepm_pkg::P_TXLO;
        end
        // during a data byte the entry after the current one is fetched
        if (i_go)
            rd_addr = (n_stg == iepm_pkg::STG_DATA) ? n_ri + 8'd1 : n_ri;
        else
            rd_addr = (r_stg == iepm_pkg::STG_DATA) ? r_ri + 8'd1 : r_ri;
        o_buf_req.raddr = rd_addr[iepm_pkg::BufAw-1:0];
        n_res.busy_res = (n_ph != iepm_pkg::P_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph <= iepm_pkg::P_IDLE; r_stg <= iepm_pkg::STG_DEVW;
            r_bc <= '0; r_sh <= '0; r_aw <= '0; r_ca <= '0; r_bl <= '0;
            r_cl <= '0; r_sa <= '0; r_sl <= '0; r_ri <= '0; r_li <= '0;
            r_at <= '0; r_dc <= '0; r_rd <= 1'b0;
            o_res <= '0;
        end else if (i_go) begin
            r_ph <= n_ph; r_stg <= n_stg; r_bc <= n_bc; r_sh <= n_sh;
            r_aw <= n_aw; r_ca <= n_ca; r_bl <= n_bl; r_cl <= n_cl;
            r_sa <= n_sa; r_sl <= n_sl; r_ri <= n_ri; r_li <= n_li;
            r_at <= n_at; r_dc <= n_dc; r_rd <= n_rd;
            o_res <= n_res;
        end
    end
endmodule
`default_nettype wire

// File: design/iepm_chk.sv
// Port checker for the I2C EEPROM master, bound to the top level.
// Depends on the top level's ports only.
`default_nettype none
module iepm_chk (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [15:0] m_axis_tdata
);
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[13] |-> !m_axis_tdata[12])
        else $error("done while busy");
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[14] |-> m_axis_tdata[13])
        else $error("status without done");
    a_rv_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[11] |-> !m_axis_tdata[2] && m_axis_tdata[0])
        else $error("read byte outside receive phase");
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("stalled with empty output");
endmodule

bind i2c_eeprom_paged_master iepm_chk u_chk (.*);
`default_nettype wire
